@@ src/javt_pkg.sv @@
// Package for the joint-action value table: sizes, mode codes, states.
// No dependencies.
package javt_pkg;
    localparam int MaxActions = 8;
    localparam int IdxW = 3;
    localparam int CellW = 6;
    localparam int ValW = 32;
    localparam int ProbW = 17;
    localparam int SumW = 56;
    localparam logic [ProbW-1:0] ProbOne = 17'd65536;
    localparam logic [ProbW-1:0] FlatScore = 17'd32768;

    typedef enum logic [2:0] {
        MODE_WR_VAL = 3'd0,
        MODE_WR_PROB = 3'd1,
        MODE_BEST = 3'd2,
        MODE_MAX = 3'd3,
        MODE_CONF = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CFG_N0 = 2'd0,
        CFG_N1 = 2'd1,
        CFG_MAXTOL = 2'd2,
        CFG_FLATTOL = 2'd3
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN,
        ST_ROW_RD,
        ST_ROW,
        ST_MUL,
        ST_ACC,
        ST_ROW_END,
        ST_CONF,
        ST_DIV,
        ST_OUT
    } t_state;

    function automatic logic [3:0] in_use(input logic [3:0] r);
        if (r == 4'd0) return 4'd1;
        if (r > 4'(MaxActions)) return 4'(MaxActions);
        return r;
    endfunction
endpackage

@@ src/joint_action_value_table.sv @@
// Joint-action value table with sequencer, shared compare/multiply unit and divider.
// Depends on javt_pkg.
//
// channel | direction | handshake
// in      | input     | i_valid / o_stall
// out     | output    | o_valid / i_stall
// cfg     | input     | i_cfg_valid / o_cfg_ready
//
// After reset a clearing pass zeroes all 64 table words; no word is taken meanwhile.
// Writes finish in idle. A max query scans the table with registered table reads;
// best action and conformance then make a row pass, and conformance runs 16 divider
// steps. One word is worked on at a time; results wait in the output register.
module joint_action_value_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [2:0]  i_row,
    input  logic [2:0]  i_col,
    input  logic signed [31:0] i_entry_value,
    input  logic [2:0]  i_prob_index,
    input  logic [16:0] i_prob_value,
    input  logic        i_player,
    input  logic [2:0]  i_action,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_best_action,
    output logic signed [31:0] o_max_value,
    output logic [16:0] o_conformance,
    output logic        o_status
);
    logic signed [31:0] r_mem [0:63];
    logic signed [31:0] r_rd;
    logic [5:0] r_rd_addr;
    logic        r_we;
    logic [5:0]  r_waddr;
    logic signed [31:0] r_wdata;
    logic [16:0] r_probs [0:7];

    logic [3:0]  r_n0, r_n1;
    logic [15:0] r_maxtol, r_flattol;

    javt_pkg::t_state r_state, n_state;
    logic [2:0]  r_mode;
    logic        r_player;
    logic [2:0]  r_action;
    logic [2:0]  r_i, r_j;
    logic [5:0]  r_clr;
    logic signed [31:0] r_hi, r_lo, r_act;
    logic        r_first;
    logic        r_cand, r_found;
    logic [2:0]  r_best;
    logic signed [55:0] r_sum, r_bsum;
    logic signed [49:0] r_prod;
    logic [32:0] r_rem, r_span;
    logic [16:0] r_q;
    logic [4:0]  r_k;

    logic        r_ovalid;
    logic [2:0]  r_obest;
    logic signed [31:0] r_omax;
    logic [16:0] r_oconf;
    logic        r_ostat;

    logic [3:0] w_n0, w_n1, w_nown, w_nopp;
    logic       w_accept;
    logic [5:0] w_addr;
    logic [32:0] w_diff, w_rem2;
    logic signed [32:0] w_gap;

    assign w_n0 = javt_pkg::in_use(r_n0);
    assign w_n1 = javt_pkg::in_use(r_n1);
    assign w_nown = r_player ? w_n1 : w_n0;
    assign w_nopp = r_player ? w_n0 : w_n1;
    assign o_stall = (r_state != javt_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == javt_pkg::ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_best_action = r_obest;
    assign o_max_value = r_omax;
    assign o_conformance = r_oconf;
    assign o_status = r_ostat;

    // Cell address: outside the table scan, own action is row for player zero, column for player one.
    always_comb begin
        if (r_state == javt_pkg::ST_SCAN_RD || r_state == javt_pkg::ST_SCAN)
            w_addr = {r_i, r_j};
        else if (r_player)
            w_addr = {r_j, r_i};
        else
            w_addr = {r_i, r_j};
    end

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        r_rd <= r_mem[w_addr];
        r_rd_addr <= w_addr;
    end

    assign w_gap = {r_hi[31], r_hi} - {r_rd[31], r_rd};
    assign w_diff = 33'({r_act[31], r_act} - {r_lo[31], r_lo});
    assign w_rem2 = {r_rem[31:0], 1'b0};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            javt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        javt_pkg::MODE_BEST, javt_pkg::MODE_MAX, javt_pkg::MODE_CONF:
                            n_state = javt_pkg::ST_SCAN_RD;
                        default: n_state = javt_pkg::ST_IDLE;
                    endcase
                    if ((i_mode == javt_pkg::MODE_BEST || i_mode == javt_pkg::MODE_MAX
                         || i_mode == javt_pkg::MODE_CONF) && r_ovalid && i_stall)
                        n_state = javt_pkg::ST_SCAN_RD;
                end
            end
            javt_pkg::ST_CLEAR: if (r_clr == 6'd63) n_state = javt_pkg::ST_IDLE;
            javt_pkg::ST_SCAN_RD: n_state = javt_pkg::ST_SCAN;
            javt_pkg::ST_SCAN: begin
                if ({1'b0, r_j} + 4'd1 < w_n1) n_state = javt_pkg::ST_SCAN_RD;
                else if ({1'b0, r_i} + 4'd1 < w_n0) n_state = javt_pkg::ST_SCAN_RD;
                else if (r_mode == javt_pkg::MODE_MAX) n_state = javt_pkg::ST_OUT;
                else n_state = javt_pkg::ST_ROW_RD;
            end
            javt_pkg::ST_ROW_RD: n_state = javt_pkg::ST_ROW;
            javt_pkg::ST_ROW: begin
                if ({1'b0, r_j} + 4'd1 < w_nopp) n_state = javt_pkg::ST_ROW_RD;
                else if (r_mode == javt_pkg::MODE_CONF) n_state = javt_pkg::ST_CONF;
                else if (r_cand || (w_gap < 33'sd0 ? 1'b0 :
                         w_gap < $signed({17'd0, r_maxtol}))) n_state = javt_pkg::ST_MUL;
                else n_state = javt_pkg::ST_ROW_END;
            end
            javt_pkg::ST_MUL: n_state = javt_pkg::ST_ACC;
            javt_pkg::ST_ACC: begin
                if ({1'b0, r_j} + 4'd1 < w_nopp) n_state = javt_pkg::ST_MUL;
                else n_state = javt_pkg::ST_ROW_END;
            end
            javt_pkg::ST_ROW_END: begin
                if ({1'b0, r_i} + 4'd1 < w_nown) n_state = javt_pkg::ST_ROW_RD;
                else n_state = javt_pkg::ST_OUT;
            end
            javt_pkg::ST_CONF: n_state = javt_pkg::ST_DIV;
            javt_pkg::ST_DIV: if (r_k == 5'd15) n_state = javt_pkg::ST_OUT;
            javt_pkg::ST_OUT: if (!r_ovalid || !i_stall) n_state = javt_pkg::ST_IDLE;
            default: n_state = javt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= javt_pkg::ST_CLEAR;
            r_clr <= '0;
            r_we <= 1'b0;
            r_ovalid <= 1'b0;
            r_n0 <= 4'd2;
            r_n1 <= 4'd2;
            r_maxtol <= 16'd7;
            r_flattol <= 16'd1;
        end else begin
            r_state <= n_state;
            r_we <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (javt_pkg::t_cfg'(i_cfg_index))
                    javt_pkg::CFG_N0: r_n0 <= i_cfg_data[3:0];
                    javt_pkg::CFG_N1: r_n1 <= i_cfg_data[3:0];
                    javt_pkg::CFG_MAXTOL: r_maxtol <= i_cfg_data;
                    javt_pkg::CFG_FLATTOL: r_flattol <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                javt_pkg::ST_CLEAR: begin
                    r_we <= 1'b1;
                    r_waddr <= r_clr;
                    r_wdata <= '0;
                    r_clr <= r_clr + 6'd1;
                end
                javt_pkg::ST_IDLE: if (w_accept) begin
                    r_mode <= i_mode;
                    r_player <= i_player;
                    r_action <= i_action;
                    r_i <= '0;
                    r_j <= '0;
                    r_first <= 1'b1;
                    r_found <= 1'b0;
                    r_best <= '0;
                    if (i_mode == javt_pkg::MODE_WR_VAL) begin
                        r_we <= 1'b1;
                        r_waddr <= {i_row, i_col};
                        r_wdata <= i_entry_value;
                    end
                    if (i_mode == javt_pkg::MODE_WR_PROB)
                        r_probs[i_prob_index] <= (i_prob_value > javt_pkg::ProbOne)
                                                 ? javt_pkg::ProbOne : i_prob_value;
                end
                javt_pkg::ST_SCAN: begin
                    if (r_first || r_rd > r_hi) r_hi <= r_rd;
                    if (r_first || r_rd < r_lo) r_lo <= r_rd;
                    r_first <= 1'b0;
                    if ({1'b0, r_j} + 4'd1 < w_n1) r_j <= r_j + 3'd1;
                    else begin
                        r_j <= '0;
                        if ({1'b0, r_i} + 4'd1 < w_n0) r_i <= r_i + 3'd1;
                        else r_i <= (r_mode == javt_pkg::MODE_CONF) ? r_action : 3'd0;
                    end
                    r_cand <= 1'b0;
                end
                javt_pkg::ST_ROW: begin
                    if (r_j == 3'd0 || r_rd > r_act) r_act <= r_rd;
                    if (w_gap >= 33'sd0 && w_gap < $signed({17'd0, r_maxtol}))
                        r_cand <= 1'b1;
                    if ({1'b0, r_j} + 4'd1 < w_nopp) r_j <= r_j + 3'd1;
                    else r_j <= '0;
                    r_sum <= '0;
                end
                javt_pkg::ST_MUL: ;
                javt_pkg::ST_ACC: begin
                    r_sum <= r_sum + 56'(r_prod);
                    if ({1'b0, r_j} + 4'd1 < w_nopp) r_j <= r_j + 3'd1;
                end
                javt_pkg::ST_ROW_END: begin
                    if (r_cand && (!r_found || r_sum > r_bsum)) begin
                        r_found <= 1'b1;
                        r_best <= r_i;
                        r_bsum <= r_sum;
                    end
                    r_cand <= 1'b0;
                    r_j <= '0;
                    r_i <= r_i + 3'd1;
                end
                javt_pkg::ST_CONF: begin
                    r_span <= 33'({r_hi[31], r_hi} - {r_lo[31], r_lo});
                    r_rem <= w_diff;
                    r_q <= '0;
                    r_k <= '0;
                end
                javt_pkg::ST_DIV: begin
                    r_k <= r_k + 5'd1;
                    if (w_rem2 >= r_span) begin
                        r_rem <= w_rem2 - r_span;
                        r_q <= {r_q[15:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2;
                        r_q <= {r_q[15:0], 1'b0};
                    end
                end
                javt_pkg::ST_OUT: if (!r_ovalid || !i_stall) begin
                    r_ovalid <= 1'b1;
                    r_obest <= '0;
                    r_omax <= '0;
                    r_oconf <= '0;
                    r_ostat <= 1'b0;
                    if (r_mode == javt_pkg::MODE_BEST) r_obest <= r_best;
                    else if (r_mode == javt_pkg::MODE_MAX) r_omax <= r_hi;
                    else if ({1'b0, r_action} >= w_nown) r_ostat <= 1'b1;
                    else if (r_span < {17'd0, r_flattol}) r_oconf <= javt_pkg::FlatScore;
                    else if (r_act == r_hi) r_oconf <= javt_pkg::ProbOne;
                    else r_oconf <= r_q;
                end
                default: ;
            endcase
        end
    end

    function automatic logic [2:0] opp_of_rd();
        return r_player ? r_rd_addr[5:3] : r_rd_addr[2:0];
    endfunction

    // Shared multiplier: the read lags by a state, so read and multiply are staged.
    always_ff @(posedge i_clk) begin
        r_prod <= $signed({{18{r_rd[31]}}, r_rd}) * $signed({33'd0, r_probs[opp_of_rd()]});
    end
endmodule

@@ src/javt_checker.sv @@
// Port-level checker for joint_action_value_table, bound to the top level.
// Depends on joint_action_value_table only through the bind below.
module javt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_cfg_ready,
    input logic [2:0] o_best_action,
    input logic o_status,
    input logic [16:0] o_conformance
);
    // A result held under stall keeps its best action and status.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_best_action) && $stable(o_status))
        else $error("result changed under stall");
    // Configuration is open exactly when words are.
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !o_stall) else $error("cfg ready mismatch");
    // An out-of-range action carries no score.
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_conformance == 17'd0) else $error("status with score");
    // Conformance never exceeds one.
    a_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_conformance <= 17'd65536) else $error("score above one");
endmodule

bind joint_action_value_table javt_checker u_javt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_cfg_ready(o_cfg_ready),
    .o_best_action(o_best_action), .o_status(o_status), .o_conformance(o_conformance)
);

@@ verif/tb.sv @@
// Self-checking bench for joint_action_value_table: directed table, then random phases.
// Depends on javt_pkg and the block's top module.
module tb;
    localparam logic [2:0] ModeSpareLo = 3'd5;
    localparam logic [2:0] ModeSpareHi = 3'd7;
    localparam int SettleCycles = 400;

    typedef struct {
        logic [2:0]  mode;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] ev;
        logic [2:0]  pidx;
        logic [16:0] pval;
        logic        player;
        logic [2:0]  act;
    } t_word;

    typedef struct {
        logic [2:0]  best;
        logic [31:0] maxv;
        logic [16:0] conf;
        logic        status;
    } t_answer;

    typedef struct {
        t_word   w;
        bit      typed;
        t_answer ans;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_mode = '0;
    logic [2:0]  i_row = '0;
    logic [2:0]  i_col = '0;
    logic signed [31:0] i_entry_value = '0;
    logic [2:0]  i_prob_index = '0;
    logic [16:0] i_prob_value = '0;
    logic        i_player = 1'b0;
    logic [2:0]  i_action = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_best_action;
    logic signed [31:0] o_max_value;
    logic [16:0] o_conformance;
    logic        o_status;

    joint_action_value_table dut (.*);

    // Shadow copy of the block's state and registers.
    longint    shadow_tbl[64];
    longint    shadow_prob[8];
    logic [3:0]  n0_reg, n1_reg;
    logic [15:0] maxtol_reg, flattol_reg;

    t_answer answers_due[$];
    int errors = 0;
    int answers_seen = 0;
    int words_sent = 0;
    int snd_idle = 0;
    int rcv_idle = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic int used(logic [3:0] r);
        if (r == 4'd0) return 1;
        if (r > 4'd8) return 8;
        return int'(r);
    endfunction

    function automatic longint entry_at(bit p, int own, int opp);
        return p ? shadow_tbl[opp * 8 + own] : shadow_tbl[own * 8 + opp];
    endfunction

    function automatic longint table_extreme(bit want_max);
        longint m;
        m = shadow_tbl[0];
        for (int i = 0; i < used(n0_reg); i++)
            for (int j = 0; j < used(n1_reg); j++)
                if (want_max ? shadow_tbl[i*8+j] > m : shadow_tbl[i*8+j] < m)
                    m = shadow_tbl[i*8+j];
        return m;
    endfunction

    function automatic logic [2:0] pick_best(bit p);
        int n_own, n_opp, best;
        longint mx, sum, best_sum;
        bit found, cand;
        n_own = p ? used(n1_reg) : used(n0_reg);
        n_opp = p ? used(n0_reg) : used(n1_reg);
        mx = table_extreme(1'b1);
        found = 0;
        best = 0;
        best_sum = 0;
        for (int i = 0; i < n_own; i++) begin
            cand = 0;
            for (int j = 0; j < n_opp; j++)
                if (mx - entry_at(p, i, j) < longint'(maxtol_reg)) cand = 1;
            if (cand) begin
                sum = 0;
                for (int j = 0; j < n_opp; j++) sum += entry_at(p, i, j) * shadow_prob[j];
                if (!found || sum > best_sum) begin
                    found = 1;
                    best = i;
                    best_sum = sum;
                end
            end
        end
        return 3'(best);
    endfunction

    function automatic logic [16:0] conform_score(bit p, int a);
        int n_opp;
        longint hi, lo, actual, span, rem;
        logic [16:0] q;
        n_opp = p ? used(n0_reg) : used(n1_reg);
        hi = table_extreme(1'b1);
        lo = table_extreme(1'b0);
        actual = entry_at(p, a, 0);
        for (int j = 1; j < n_opp; j++)
            if (entry_at(p, a, j) > actual) actual = entry_at(p, a, j);
        span = hi - lo;
        if (span < longint'(flattol_reg)) return javt_pkg::FlatScore;
        if (actual == hi) return javt_pkg::ProbOne;
        rem = actual - lo;
        q = '0;
        for (int k = 0; k < 16; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= span) begin
                rem -= span;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Applies one accepted word to the shadow state; returns 1 when it yields an answer.
    function automatic bit apply_word(t_word w, output t_answer a);
        int n_own;
        a = '{default: '0};
        case (w.mode)
            javt_pkg::MODE_WR_VAL: begin
                shadow_tbl[w.row * 8 + w.col] = longint'(signed'(w.ev));
                return 0;
            end
            javt_pkg::MODE_WR_PROB: begin
                shadow_prob[w.pidx] = (w.pval > javt_pkg::ProbOne) ? javt_pkg::ProbOne : w.pval;
                return 0;
            end
            javt_pkg::MODE_BEST: a.best = pick_best(w.player);
            javt_pkg::MODE_MAX: a.maxv = 32'(table_extreme(1'b1));
            javt_pkg::MODE_CONF: begin
                n_own = w.player ? used(n1_reg) : used(n0_reg);
                if (int'(w.act) >= n_own) a.status = 1'b1;
                else a.conf = conform_score(w.player, int'(w.act));
            end
            default: return 0;
        endcase
        return 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Receiver: random stall and answer checking.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                answers_seen++;
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected answer", o_max_value, 0);
                end else begin
                    want = answers_due.pop_front();
                    if (o_best_action !== want.best)
                        report_mismatch("best_action", o_best_action, want.best);
                    if (o_max_value !== want.maxv)
                        report_mismatch("max_value", o_max_value, signed'(want.maxv));
                    if (o_conformance !== want.conf)
                        report_mismatch("conformance", o_conformance, want.conf);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            i_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    task automatic send_word(t_word w, bit typed, t_answer typed_ans);
        t_answer a;
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= w.mode;
        i_row <= w.row;
        i_col <= w.col;
        i_entry_value <= w.ev;
        i_prob_index <= w.pidx;
        i_prob_value <= w.pval;
        i_player <= w.player;
        i_action <= w.act;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        if (apply_word(w, a)) answers_due.push_back(typed ? typed_ans : a);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Valid stays high across back-to-back register writes; set_regs drops it.
    task automatic write_reg(javt_pkg::t_cfg idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            javt_pkg::CFG_N0: n0_reg = data[3:0];
            javt_pkg::CFG_N1: n1_reg = data[3:0];
            javt_pkg::CFG_MAXTOL: maxtol_reg = data;
            default: flattol_reg = data;
        endcase
    endtask

    task automatic set_regs(logic [3:0] n0, logic [3:0] n1, logic [15:0] mt, logic [15:0] ft);
        drain();
        write_reg(javt_pkg::CFG_N0, {12'($urandom_range(12'hFFF)), n0});
        write_reg(javt_pkg::CFG_N1, {12'($urandom_range(12'hFFF)), n1});
        write_reg(javt_pkg::CFG_MAXTOL, mt);
        write_reg(javt_pkg::CFG_FLATTOL, ft);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0, 1: return 32'($signed($urandom_range(20)) - 10);
            2: return 32'h7FFF_FFFF - $urandom_range(8);
            3: return 32'h8000_0000 + $urandom_range(8);
            4: return 32'($signed($urandom_range(20)) - 10) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_word random_word();
        t_word w;
        int pick;
        w.row = 3'($urandom_range(7));
        w.col = 3'($urandom_range(7));
        w.ev = pick_value();
        w.pidx = 3'($urandom_range(7));
        w.pval = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        w.player = 1'($urandom_range(1));
        w.act = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 45) w.mode = javt_pkg::MODE_WR_VAL;
        else if (pick < 55) w.mode = javt_pkg::MODE_WR_PROB;
        else if (pick < 70) w.mode = javt_pkg::MODE_BEST;
        else if (pick < 82) w.mode = javt_pkg::MODE_MAX;
        else if (pick < 97) w.mode = javt_pkg::MODE_CONF;
        else w.mode = $urandom_range(1) ? ModeSpareLo : ModeSpareHi;
        return w;
    endfunction

    function automatic t_row mk(logic [2:0] m, logic [2:0] r, logic [2:0] c, logic [31:0] ev,
                                logic [2:0] pi, logic [16:0] pv, logic pl, logic [2:0] ac);
        t_row x;
        x.w = '{m, r, c, ev, pi, pv, pl, ac};
        x.typed = 0;
        x.ans = '{default: '0};
        return x;
    endfunction

    initial begin
        t_row dir[$];
        t_row x;
        t_word w;
        t_answer none;
        int total;
        none = '{default: '0};
        foreach (shadow_tbl[i]) shadow_tbl[i] = 0;
        foreach (shadow_prob[i]) shadow_prob[i] = 0;
        n0_reg = 4'd2;
        n1_reg = 4'd2;
        maxtol_reg = 16'd7;
        flattol_reg = 16'd1;

        // Checks against values that follow straight from reset and from the extremes.
        x = mk(javt_pkg::MODE_MAX, 0, 0, 0, 0, 0, 0, 0); x.typed = 1; dir.push_back(x);
        x = mk(javt_pkg::MODE_CONF, 0, 0, 0, 0, 0, 0, 0); x.typed = 1;
        x.ans.conf = javt_pkg::FlatScore;
        dir.push_back(x);
        x = mk(javt_pkg::MODE_CONF, 0, 0, 0, 0, 0, 0, 2); x.typed = 1; x.ans.status = 1;
        dir.push_back(x);
        x = mk(javt_pkg::MODE_CONF, 0, 0, 0, 0, 0, 1, 7); x.typed = 1; x.ans.status = 1;
        dir.push_back(x);
        // Probabilities go in before any best-action query reads them.
        dir.push_back(mk(javt_pkg::MODE_WR_PROB, 0, 0, 0, 0, 17'd65536, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_PROB, 0, 0, 0, 1, 17'h1FFFF, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_PROB, 0, 0, 0, 2, 17'd0, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_PROB, 0, 0, 0, 3, 17'd1, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_PROB, 0, 0, 0, 4, 17'd32768, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_PROB, 0, 0, 0, 5, 17'd100, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_PROB, 0, 0, 0, 6, 17'd65535, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_PROB, 0, 0, 0, 7, 17'd70000, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_VAL, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_VAL, 7, 7, 32'h8000_0000, 0, 0, 0, 0));
        x = mk(javt_pkg::MODE_MAX, 0, 0, 0, 0, 0, 0, 0); x.typed = 1;
        x.ans.maxv = 32'h7FFF_FFFF;
        dir.push_back(x);
        dir.push_back(mk(javt_pkg::MODE_WR_VAL, 1, 1, -32'sd5, 0, 0, 0, 0));
        x = mk(javt_pkg::MODE_CONF, 0, 0, 0, 0, 0, 0, 0); x.typed = 1;
        x.ans.conf = javt_pkg::ProbOne;
        dir.push_back(x);
        dir.push_back(mk(javt_pkg::MODE_CONF, 0, 0, 0, 0, 0, 1, 1));
        dir.push_back(mk(javt_pkg::MODE_BEST, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_BEST, 0, 0, 0, 0, 0, 1, 0));
        dir.push_back(mk(ModeSpareLo, 7, 7, 32'hFFFF_FFFF, 7, 17'h1FFFF, 1, 7));
        dir.push_back(mk(ModeSpareHi, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_WR_VAL, 0, 1, 32'h7FFF_FFFF, 0, 0, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_BEST, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(javt_pkg::MODE_MAX, 0, 0, 0, 0, 0, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_regs(4'd2, 4'd2, 16'd7, 16'd1);

        foreach (dir[i]) send_word(dir[i].w, dir[i].typed, dir[i].ans);

        total = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_regs(4'd0, 4'd15, 16'd0, 16'd0);
                1: set_regs(4'd8, 4'd8, 16'hFFFF, 16'hFFFF);
                2: set_regs(4'd1, 4'd1, 16'd0, 16'd0);
                default: set_regs(4'($urandom_range(15)), 4'($urandom_range(15)),
                                  $urandom_range(1) ? 16'($urandom_range(40)) : 16'($urandom),
                                  $urandom_range(1) ? 16'($urandom_range(40)) : 16'($urandom));
            endcase
            for (int k = 0; k < 200; k++) begin
                if (total < 533) begin
                    snd_idle = 35; rcv_idle = 66;
                end else if (total < 1066) begin
                    snd_idle = 66; rcv_idle = 35;
                end else begin
                    snd_idle = 0; rcv_idle = 0;
                end
                if (ph == 4 && k == 100) drain();
                w = random_word();
                send_word(w, 1'b0, none);
                if (w.mode <= javt_pkg::MODE_CONF) total++;
            end
        end

        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        $display("tb: %0d words sent, %0d answers checked over 9 register settings",
                 words_sent, answers_seen);
        $display("tb: covered value and probability writes, max, best action and conformance");
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

@@ sim.f @@
src/javt_pkg.sv
src/joint_action_value_table.sv
src/javt_checker.sv
verif/tb.sv
